// ===== rtl/aarch64_instruction_decoder_unit_assert.svh =====
// Assertion macros for the instruction decoder unit.
`ifndef AARCH64_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define AARCH64_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define A64D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define A64D_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define A64D_ASSERT(label, prop, msg)
`define A64D_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== rtl/a64dec_pkg.sv =====
// Package: types, codes and the classify function of the instruction decoder.
package a64dec_pkg;
    localparam int unsigned QDepth = 2;
    localparam logic [6:0] MnUnknown = 7'd73;
    localparam logic [3:0] CatOther = 4'd8;

    typedef enum logic [3:0] {
        CL_NONE, CL_ADR, CL_ADDI, CL_MOVW, CL_B, CL_CB, CL_BCOND, CL_TB, CL_BR,
        CL_LS, CL_DPR, CL_SYS, CL_EXC
    } cls_t;

    typedef struct packed {
        logic [31:0] word;
        logic        whole;
        logic [63:0] pc;
        cls_t        cls;
        logic        pro;
        logic        epi;
    } front_item_t;

    typedef struct packed {
        logic        decoded;
        logic [6:0]  mnemonic_id;
        logic [3:0]  category;
        logic [1:0]  operand_count;
        logic [8:0]  slot_kinds;
        logic [6:0]  reg_first;
        logic [6:0]  reg_second;
        logic [6:0]  reg_third;
        logic [63:0] immediate;
        logic [63:0] target;
        logic [7:0]  flags;
    } result_t;

    function automatic cls_t classify(input logic [31:0] w);
        logic [6:0] op0;
        op0 = w[31:25];
        if ((op0 & 7'h71) == 7'h10) return CL_ADR;
        else if ((op0 & 7'h71) == 7'h11) return CL_ADDI;
        else if ((op0 & 7'h3F) == 7'h25) return CL_MOVW;
        else if ((op0 & 7'h7C) == 7'h14) return CL_B;
        else if ((op0 & 7'h7E) == 7'h34) return CL_CB;
        else if ((op0 & 7'h7E) == 7'h54) return CL_BCOND;
        else if ((op0 & 7'h7E) == 7'h36) return CL_TB;
        else if ((op0 & 7'h7E) == 7'h6A) return CL_BR;
        else if ((op0 & 7'h0A) == 7'h08) return CL_LS;
        else if ((op0 & 7'h0E) == 7'h0A) return CL_DPR;
        else if ((w & 32'hFFC00000) == 32'hD5000000) return CL_SYS;
        else if ((w & 32'hFF000000) == 32'hD4000000) return CL_EXC;
        return CL_NONE;
    endfunction

    function automatic logic [6:0] reg_code(input logic [4:0] num, input logic x,
                                            input logic sp);
        if (num == 5'd31) begin
            if (sp) return x ? 7'd32 : 7'd65;
            return x ? 7'd31 : 7'd64;
        end
        return x ? {2'b00, num} : 7'd33 + {2'b00, num};
    endfunction
endpackage

// ===== rtl/a64dec_if.sv =====
// Valid/ready channel interface carrying one item.
interface a64dec_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    logic        whole_word;
    logic [63:0] pc_address;
    modport source (output valid, instruction_word, whole_word, pc_address, input ready);
    modport sink (input valid, instruction_word, whole_word, pc_address, output ready);
endinterface

interface a64dec_out_if;
    logic        valid;
    logic        ready;
    logic        decoded;
    logic [6:0]  mnemonic_id;
    logic [3:0]  category;
    logic [1:0]  operand_count;
    logic [8:0]  slot_kinds;
    logic [6:0]  reg_first;
    logic [6:0]  reg_second;
    logic [6:0]  reg_third;
    logic [63:0] immediate;
    logic [63:0] target;
    logic [7:0]  flags;
    modport source (output valid, decoded, mnemonic_id, category, operand_count, slot_kinds,
        reg_first, reg_second, reg_third, immediate, target, flags, input ready);
    modport sink (input valid, decoded, mnemonic_id, category, operand_count, slot_kinds,
        reg_first, reg_second, reg_third, immediate, target, flags, output ready);
endinterface

// ===== rtl/a64dec_front.sv =====
// Front end: takes an item, classifies it and matches prologue/epilogue patterns.
module a64dec_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    a64dec_in_if.sink             in_ch,
    output logic                  f_valid,
    input  logic                  f_ready,
    output a64dec_pkg::front_item_t f_item
);
    logic                    valid_reg;
    a64dec_pkg::front_item_t item_reg;
    a64dec_pkg::front_item_t item_next;
    logic [31:0]             w;

    assign w = in_ch.instruction_word;
    assign in_ch.ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item = item_reg;

    always_comb
    begin
        item_next.word  = w;
        item_next.whole = in_ch.whole_word;
        item_next.pc    = in_ch.pc_address;
        item_next.cls   = a64dec_pkg::classify(w);
        item_next.pro   = in_ch.whole_word && (((w & 32'hFFC07FFF) == 32'hA9007BFD)
            || ((w & 32'hFF0003FF) == 32'hD10003FF) || w == 32'hD503233F
            || w == 32'hD503237F);
        item_next.epi   = in_ch.whole_word && (((w & 32'hFFFFFC1F) == 32'hD65F0000)
            || w == 32'hD65F0BFF || w == 32'hD65F0FFF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ch.ready)
            valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            item_reg <= item_next;
    end
endmodule

// ===== rtl/a64dec_queue.sv =====
// Short queue between front and back end.
module a64dec_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_valid,
    output logic                    wr_ready,
    input  a64dec_pkg::front_item_t wr_item,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output a64dec_pkg::front_item_t rd_item
);
    `include "aarch64_instruction_decoder_unit_assert.svh"
    localparam int unsigned PtrW = $clog2(a64dec_pkg::QDepth);
    a64dec_pkg::front_item_t mem_reg [a64dec_pkg::QDepth];
    logic [PtrW-1:0] wp_reg, rp_reg;
    logic [PtrW:0]   cnt_reg;
    logic            push, pop;

    assign wr_ready = cnt_reg != (PtrW+1)'(a64dec_pkg::QDepth);
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wr_item;
    end

    `A64D_ASSERT(q_no_overflow, (cnt_reg == (PtrW+1)'(a64dec_pkg::QDepth)) |-> !push,
        "queue push when full")
    `A64D_ASSERT(q_count_step, (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1),
        "queue count did not rise")
    `A64D_ASSERT_RST(q_reset_empty, !rst_n |-> (cnt_reg == '0), "queue not empty in reset")
endmodule

// ===== rtl/a64dec_back.sv =====
// Back end: field extraction, register coding and target add, into an output register.
module a64dec_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    b_valid,
    output logic                    b_ready,
    input  a64dec_pkg::front_item_t b_item,
    a64dec_out_if.source            out_ch
);
    `include "aarch64_instruction_decoder_unit_assert.svh"
    logic                valid_reg;
    a64dec_pkg::result_t res_reg, r;
    logic [31:0] w;
    logic [63:0] pc, tb, toff;
    logic        sf, sub, setf, neg, ld;
    logic [4:0]  rd, rn, rm;
    logic [3:0]  opc4;
    logic [4:0]  k;
    logic [6:0]  h;
    logic [1:0]  opc2;

    assign b_ready = !valid_reg || out_ch.ready;

    always_comb
    begin
        w = b_item.word;
        pc = b_item.pc;
        sf = w[31];
        rd = w[4:0];
        rn = w[9:5];
        rm = w[20:16];
        sub = w[30];
        setf = w[29];
        neg = w[21];
        ld = w[22];
        opc4 = w[24:21];
        opc2 = w[30:29];
        k = {w[23:21], w[1:0]};
        h = {w[11:8], w[7:5]};
        tb = pc;
        toff = '0;
        r = '0;
        r.mnemonic_id = a64dec_pkg::MnUnknown;
        r.category = a64dec_pkg::CatOther;
        case (b_item.cls)
            a64dec_pkg::CL_ADR:
            begin
                r.mnemonic_id = sf ? 7'd1 : 7'd0;
                r.category = 4'd0;
                r.operand_count = 2'd2;
                r.slot_kinds = 9'o031;
                r.reg_first = a64dec_pkg::reg_code(rd, 1'b1, 1'b0);
                if (sf)
                begin
                    tb = pc & ~64'hFFF;
                    toff = {{31{w[23]}}, w[23:5], w[30:29], 12'h000};
                end
                else
                    toff = {{43{w[23]}}, w[23:5], w[30:29]};
            end
            a64dec_pkg::CL_ADDI:
            begin
                r.immediate = (w[23:22] != 2'b00) ? {40'h0, w[21:10], 12'h000}
                                                  : {52'h0, w[21:10]};
                if (sub && rd == 5'd31 && setf)
                begin
                    r.mnemonic_id = 7'd2;
                    r.category = 4'd1;
                    r.operand_count = 2'd2;
                    r.slot_kinds = 9'o021;
                    r.reg_first = a64dec_pkg::reg_code(rn, sf, 1'b1);
                end
                else
                begin
                    r.mnemonic_id = 7'd3 + {5'd0, sub, 1'b0} + {6'd0, setf};
                    r.category = 4'd2;
                    r.operand_count = 2'd3;
                    r.slot_kinds = 9'o211;
                    r.reg_first = a64dec_pkg::reg_code(rd, sf, !setf);
                    r.reg_second = a64dec_pkg::reg_code(rn, sf, 1'b1);
                end
            end
            a64dec_pkg::CL_MOVW:
            begin
                r.mnemonic_id = 7'd7 + {5'd0, opc2};
                r.category = 4'd0;
                r.operand_count = 2'd2;
                r.slot_kinds = 9'o021;
                r.reg_first = a64dec_pkg::reg_code(rd, sf, 1'b0);
                r.immediate = {48'h0, w[20:5]} << {w[22:21], 4'b0000};
            end
            a64dec_pkg::CL_B:
            begin
                r.mnemonic_id = sf ? 7'd12 : 7'd11;
                r.category = sf ? 4'd3 : 4'd4;
                r.operand_count = 2'd1;
                r.flags = {6'd0, sf, 1'b1};
                r.slot_kinds = 9'o003;
                toff = {{36{w[25]}}, w[25:0], 2'b00};
            end
            a64dec_pkg::CL_CB:
            begin
                r.mnemonic_id = w[24] ? 7'd14 : 7'd13;
                r.category = 4'd4;
                r.operand_count = 2'd2;
                r.flags = 8'h09;
                r.slot_kinds = 9'o031;
                r.reg_first = a64dec_pkg::reg_code(rd, sf, 1'b0);
                toff = {{43{w[23]}}, w[23:5], 2'b00};
            end
            a64dec_pkg::CL_BCOND:
            begin
                r.mnemonic_id = 7'd15 + {3'd0, w[3:0]};
                r.category = 4'd4;
                r.operand_count = 2'd1;
                r.flags = 8'h09;
                r.slot_kinds = 9'o003;
                toff = {{43{w[23]}}, w[23:5], 2'b00};
            end
            a64dec_pkg::CL_TB:
            begin
                r.mnemonic_id = w[24] ? 7'd32 : 7'd31;
                r.category = 4'd4;
                r.operand_count = 2'd3;
                r.flags = 8'h09;
                r.slot_kinds = 9'o321;
                r.reg_first = a64dec_pkg::reg_code(rd, sf, 1'b0);
                r.immediate = {58'h0, sf, w[23:19]};
                toff = {{48{w[18]}}, w[18:5], 2'b00};
            end
            a64dec_pkg::CL_BR:
            begin
                case (opc4)
                    4'd0: begin r.mnemonic_id = 7'd33; r.category = 4'd4; r.flags = 8'h01; end
                    4'd1: begin r.mnemonic_id = 7'd34; r.category = 4'd3; r.flags = 8'h03; end
                    4'd2: begin r.mnemonic_id = 7'd35; r.category = 4'd5; r.flags = 8'h05; end
                    default: begin r.mnemonic_id = 7'd36; r.category = 4'd4; end
                endcase
                if (!(opc4 == 4'd2 && rn == 5'd30))
                begin
                    r.operand_count = 2'd1;
                    r.slot_kinds = 9'o001;
                    r.reg_first = a64dec_pkg::reg_code(rn, 1'b1, 1'b0);
                end
            end
            a64dec_pkg::CL_LS:
            begin
                if (w[29:28] == 2'd3 && w[25:24] == 2'd1)
                begin
                    r.mnemonic_id = ld ? 7'd37 : 7'd38;
                    r.category = 4'd0;
                    r.operand_count = 2'd2;
                    r.flags = ld ? 8'h10 : 8'h20;
                    r.slot_kinds = 9'o041;
                    r.reg_first = a64dec_pkg::reg_code(rd, w[31:30] == 2'd3, 1'b0);
                    r.reg_second = a64dec_pkg::reg_code(rn, 1'b1, 1'b1);
                    r.immediate = {52'h0, w[21:10]} << w[31:30];
                end
                else if (w[29:27] == 3'd5)
                begin
                    r.mnemonic_id = ld ? 7'd39 : 7'd40;
                    r.category = ld ? 4'd0 : 4'd6;
                    r.operand_count = 2'd3;
                    r.flags = ld ? 8'h10 : 8'h20;
                    r.slot_kinds = 9'o411;
                    r.reg_first = a64dec_pkg::reg_code(rd, sf, 1'b0);
                    r.reg_second = a64dec_pkg::reg_code(w[14:10], sf, 1'b0);
                    r.reg_third = a64dec_pkg::reg_code(rn, 1'b1, 1'b1);
                    r.immediate = sf ? {{54{w[21]}}, w[21:15], 3'b000}
                                     : {{55{w[21]}}, w[21:15], 2'b00};
                end
                else
                begin
                    r.mnemonic_id = 7'd41;
                    r.category = 4'd0;
                end
            end
            a64dec_pkg::CL_DPR:
            begin
                if (w[28:25] == 4'b0101)
                begin
                    r.reg_first = a64dec_pkg::reg_code(rd, sf, 1'b0);
                    if (opc2 == 2'd1 && !neg && rn == 5'd31 && w[15:10] == 6'd0
                        && w[23:22] == 2'd0)
                    begin
                        r.mnemonic_id = 7'd50;
                        r.category = 4'd0;
                        r.operand_count = 2'd2;
                        r.slot_kinds = 9'o011;
                        r.reg_second = a64dec_pkg::reg_code(rm, sf, 1'b0);
                    end
                    else
                    begin
                        r.mnemonic_id = 7'd42 + {4'd0, neg, 2'b00} + {5'd0, opc2};
                        r.category = 4'd7;
                        r.operand_count = 2'd3;
                        r.slot_kinds = 9'o111;
                        r.reg_second = a64dec_pkg::reg_code(rn, sf, 1'b0);
                        r.reg_third = a64dec_pkg::reg_code(rm, sf, 1'b0);
                    end
                end
                else if (w[28:24] == 5'h0B)
                begin
                    if (sub && rd == 5'd31 && setf)
                    begin
                        r.mnemonic_id = 7'd2;
                        r.category = 4'd1;
                        r.operand_count = 2'd2;
                        r.slot_kinds = 9'o011;
                        r.reg_first = a64dec_pkg::reg_code(rn, sf, 1'b1);
                        r.reg_second = a64dec_pkg::reg_code(rm, sf, 1'b0);
                    end
                    else
                    begin
                        r.mnemonic_id = 7'd3 + {5'd0, sub, 1'b0} + {6'd0, setf};
                        r.category = 4'd2;
                        r.operand_count = 2'd3;
                        r.slot_kinds = 9'o111;
                        r.reg_first = a64dec_pkg::reg_code(rd, sf, !setf);
                        r.reg_second = a64dec_pkg::reg_code(rn, sf, 1'b1);
                        r.reg_third = a64dec_pkg::reg_code(rm, sf, 1'b0);
                    end
                end
                else
                begin
                    r.mnemonic_id = 7'd51;
                    r.category = 4'd8;
                end
            end
            a64dec_pkg::CL_SYS:
            begin
                r.category = 4'd10;
                if (w[20:19] == 2'd1 && !w[21] && rd == 5'd31)
                begin
                    if (w[15:12] == 4'd2 && w[18:16] == 3'd3)
                    begin
                        r.mnemonic_id = (h <= 7'd5) ? 7'd52 + h : 7'd58;
                        if (h == 7'd0) r.category = 4'd9;
                    end
                    else if (w[15:12] == 4'd3)
                    begin
                        case (w[7:5])
                            3'd2: r.mnemonic_id = 7'd59;
                            3'd4: r.mnemonic_id = 7'd60;
                            3'd5: r.mnemonic_id = 7'd61;
                            3'd6: r.mnemonic_id = 7'd62;
                            default: r.mnemonic_id = 7'd63;
                        endcase
                    end
                    else
                        r.mnemonic_id = 7'd64;
                end
                else if (w[20])
                begin
                    r.mnemonic_id = w[21] ? 7'd65 : 7'd66;
                    r.operand_count = 2'd1;
                    r.slot_kinds = 9'o001;
                    r.reg_first = a64dec_pkg::reg_code(rd, 1'b1, 1'b0);
                end
                else
                    r.mnemonic_id = 7'd64;
            end
            a64dec_pkg::CL_EXC:
            begin
                if (k >= 5'd1 && k <= 5'd4) r.mnemonic_id = 7'd66 + {2'd0, k};
                else if (k == 5'd8) r.mnemonic_id = 7'd71;
                else r.mnemonic_id = 7'd72;
                r.category = 4'd10;
                r.operand_count = 2'd1;
                r.slot_kinds = 9'o002;
                r.immediate = {48'h0, w[20:5]};
            end
            default: ;
        endcase
        if (r.slot_kinds[2:0] == 3'd3 || r.slot_kinds[5:3] == 3'd3
            || r.slot_kinds[8:6] == 3'd3)
            r.target = tb + toff;
        r.flags[6] = b_item.pro;
        r.flags[7] = b_item.epi;
        if (!b_item.whole)
        begin
            r = '0;
            r.mnemonic_id = a64dec_pkg::MnUnknown;
            r.category = a64dec_pkg::CatOther;
        end
        r.decoded = b_item.whole;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (b_ready)
            valid_reg <= b_valid;
    end

    always_ff @(posedge clk)
    begin
        if (b_valid && b_ready)
            res_reg <= r;
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.decoded = res_reg.decoded;
    assign out_ch.mnemonic_id = res_reg.mnemonic_id;
    assign out_ch.category = res_reg.category;
    assign out_ch.operand_count = res_reg.operand_count;
    assign out_ch.slot_kinds = res_reg.slot_kinds;
    assign out_ch.reg_first = res_reg.reg_first;
    assign out_ch.reg_second = res_reg.reg_second;
    assign out_ch.reg_third = res_reg.reg_third;
    assign out_ch.immediate = res_reg.immediate;
    assign out_ch.target = res_reg.target;
    assign out_ch.flags = res_reg.flags;

    `A64D_ASSERT(b_hold, (valid_reg && !out_ch.ready) |=> (valid_reg && $stable(res_reg)),
        "result changed under stall")
    `A64D_ASSERT(b_short, (valid_reg && !res_reg.decoded) |-> (res_reg.flags == 8'h00),
        "flags set on short word")
    `A64D_ASSERT(b_load, (b_valid && b_ready) |=> valid_reg, "taken item not shown")
endmodule

// ===== rtl/aarch64_instruction_decoder_unit.sv =====
// Top level of the AArch64 instruction decoder unit.
// Takes one instruction word, its address and a whole-word bit per cycle while in_ch is
// ready, and returns one decode result per item, back to back at one item a cycle while
// out_ch is ready. An item passes through the front register (classify, pattern match),
// an entry of the two-entry queue and the back output register (field decode and the 64-bit
// target adder). Either side may stall independently; the queue absorbs the difference.
module aarch64_instruction_decoder_unit
(
    input logic          clk,
    input logic          rst_n,
    a64dec_in_if.sink    in_ch,
    a64dec_out_if.source out_ch
);
    logic                    f_valid, f_ready, b_valid, b_ready;
    a64dec_pkg::front_item_t f_item, b_item;

    a64dec_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .f_valid(f_valid), .f_ready(f_ready), .f_item(f_item)
    );

    a64dec_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
    );

    a64dec_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .b_valid(b_valid), .b_ready(b_ready), .b_item(b_item), .out_ch(out_ch)
    );
endmodule

// ===== dv/a64dec_tb_if.sv =====
// Testbench copy note: channel interfaces are provided by the RTL; this file holds the testbench package.
`timescale 1ns / 100ps
package a64dec_tb_pkg;
    localparam logic [2:0] SlotNone = 3'd0;
    localparam logic [2:0] SlotReg  = 3'd1;
    localparam logic [2:0] SlotImm  = 3'd2;
    localparam logic [2:0] SlotLbl  = 3'd3;
    localparam logic [2:0] SlotMem  = 3'd4;

    localparam logic [7:0] FlBranch = 8'h01;
    localparam logic [7:0] FlCall   = 8'h02;
    localparam logic [7:0] FlRet    = 8'h04;
    localparam logic [7:0] FlCond   = 8'h08;
    localparam logic [7:0] FlLoad   = 8'h10;
    localparam logic [7:0] FlStore  = 8'h20;
    localparam logic [7:0] FlPro    = 8'h40;
    localparam logic [7:0] FlEpi    = 8'h80;

    localparam logic [3:0] CatTransfer = 4'd0;
    localparam logic [3:0] CatCompare  = 4'd1;
    localparam logic [3:0] CatArith    = 4'd2;
    localparam logic [3:0] CatCall     = 4'd3;
    localparam logic [3:0] CatBranch   = 4'd4;
    localparam logic [3:0] CatReturn   = 4'd5;
    localparam logic [3:0] CatStack    = 4'd6;
    localparam logic [3:0] CatLogical  = 4'd7;
    localparam logic [3:0] CatNop      = 4'd9;
    localparam logic [3:0] CatSystem   = 4'd10;
endpackage

// ===== dv/aarch64_instruction_decoder_unit_test.sv =====
// Testbench top: directed table and random instruction words checked against a decode predictor.
`timescale 1ns / 100ps
module aarch64_instruction_decoder_unit_test;
    localparam int IdleLimit = 20000;
    localparam int NumRandom = 500;

    typedef struct {
        logic [31:0]         word;
        logic                whole;
        logic [63:0]         pc;
        logic                known;
        a64dec_pkg::result_t res;
    } vector_t;

    logic clk;
    logic rst_n;
    a64dec_in_if  in_ch();
    a64dec_out_if out_ch();

    aarch64_instruction_decoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    a64dec_pkg::result_t expected_decodes[$];
    vector_t vectors[$];
    int      fail_count;
    int      idle_cycles;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
        logic [63:0] m;
        m = 64'd1 << (bits - 1);
        return ((v & ((m << 1) - 64'd1)) ^ m) - m;
    endfunction

    function automatic logic [6:0] rcode(input logic [4:0] n, input logic x, input logic sp);
        if (n == 5'd31)
        begin
            if (sp)
                return x ? 7'd32 : 7'd65;
            return x ? 7'd31 : 7'd64;
        end
        return x ? {2'b00, n} : 7'd33 + {2'b00, n};
    endfunction

    function automatic a64dec_pkg::result_t predict_decode(input logic [31:0] w,
                                                           input logic whole,
                                                           input logic [63:0] pc);
        a64dec_pkg::result_t d;
        logic [6:0] op0;
        logic sf, sub, setf, neg, ld, page;
        logic [4:0] rd, rn, rm, cls;
        logic [63:0] imm;
        logic [3:0] opc4;
        logic [1:0] size, opc;
        logic [2:0] o1, o2;
        logic [3:0] crn, crm;
        logic [5:0] h;
        logic [4:0] k;
        d = '0;
        d.mnemonic_id = a64dec_pkg::MnUnknown;
        d.category = a64dec_pkg::CatOther;
        if (!whole)
            return d;
        d.decoded = 1'b1;
        op0 = w[31:25];
        sf = w[31];
        rd = w[4:0];
        rn = w[9:5];
        rm = w[20:16];
        if ((op0 & 7'h71) == 7'h10)
        begin
            page = sf;
            imm = (sx({45'd0, w[23:5]}, 19) << 2) | {62'd0, w[30:29]};
            d.mnemonic_id = page ? 7'd1 : 7'd0;
            d.category = a64dec_tb_pkg::CatTransfer;
            d.operand_count = 2'd2;
            d.slot_kinds = {3'd0, a64dec_tb_pkg::SlotLbl, a64dec_tb_pkg::SlotReg};
            d.reg_first = rcode(rd, 1'b1, 1'b0);
            d.target = page ? (pc & ~64'hFFF) + (imm << 12) : pc + imm;
        end
        else if ((op0 & 7'h71) == 7'h11)
        begin
            sub = w[30];
            setf = w[29];
            imm = (w[23:22] != 0) ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
            d.immediate = imm;
            if (sub && rd == 5'd31 && setf)
            begin
                d.mnemonic_id = 7'd2;
                d.category = a64dec_tb_pkg::CatCompare;
                d.operand_count = 2'd2;
                d.slot_kinds = {3'd0, a64dec_tb_pkg::SlotImm, a64dec_tb_pkg::SlotReg};
                d.reg_first = rcode(rn, sf, 1'b1);
            end
            else
            begin
                d.mnemonic_id = 7'd3 + (sub ? 7'd2 : 7'd0) + (setf ? 7'd1 : 7'd0);
                d.category = a64dec_tb_pkg::CatArith;
                d.operand_count = 2'd3;
                d.slot_kinds = {a64dec_tb_pkg::SlotImm, a64dec_tb_pkg::SlotReg,
                                a64dec_tb_pkg::SlotReg};
                d.reg_first = rcode(rd, sf, !setf);
                d.reg_second = rcode(rn, sf, 1'b1);
            end
        end
        else if ((op0 & 7'h3F) == 7'h25)
        begin
            d.mnemonic_id = 7'd7 + {5'd0, w[30:29]};
            d.category = a64dec_tb_pkg::CatTransfer;
            d.operand_count = 2'd2;
            d.slot_kinds = {3'd0, a64dec_tb_pkg::SlotImm, a64dec_tb_pkg::SlotReg};
            d.reg_first = rcode(rd, sf, 1'b0);
            d.immediate = {48'd0, w[20:5]} << (16 * w[22:21]);
        end
        else if ((op0 & 7'h7C) == 7'h14)
        begin
            d.mnemonic_id = sf ? 7'd12 : 7'd11;
            d.category = sf ? a64dec_tb_pkg::CatCall : a64dec_tb_pkg::CatBranch;
            d.operand_count = 2'd1;
            d.flags = a64dec_tb_pkg::FlBranch | (sf ? a64dec_tb_pkg::FlCall : 8'h00);
            d.slot_kinds = {6'd0, a64dec_tb_pkg::SlotLbl};
            d.target = pc + (sx({38'd0, w[25:0]}, 26) << 2);
        end
        else if ((op0 & 7'h7E) == 7'h34)
        begin
            d.mnemonic_id = w[24] ? 7'd14 : 7'd13;
            d.category = a64dec_tb_pkg::CatBranch;
            d.operand_count = 2'd2;
            d.flags = a64dec_tb_pkg::FlBranch | a64dec_tb_pkg::FlCond;
            d.slot_kinds = {3'd0, a64dec_tb_pkg::SlotLbl, a64dec_tb_pkg::SlotReg};
            d.reg_first = rcode(rd, sf, 1'b0);
            d.target = pc + (sx({45'd0, w[23:5]}, 19) << 2);
        end
        else if ((op0 & 7'h7E) == 7'h54)
        begin
            d.mnemonic_id = 7'd15 + {3'd0, w[3:0]};
            d.category = a64dec_tb_pkg::CatBranch;
            d.operand_count = 2'd1;
            d.flags = a64dec_tb_pkg::FlBranch | a64dec_tb_pkg::FlCond;
            d.slot_kinds = {6'd0, a64dec_tb_pkg::SlotLbl};
            d.target = pc + (sx({45'd0, w[23:5]}, 19) << 2);
        end
        else if ((op0 & 7'h7E) == 7'h36)
        begin
            d.mnemonic_id = w[24] ? 7'd32 : 7'd31;
            d.category = a64dec_tb_pkg::CatBranch;
            d.operand_count = 2'd3;
            d.flags = a64dec_tb_pkg::FlBranch | a64dec_tb_pkg::FlCond;
            d.slot_kinds = {a64dec_tb_pkg::SlotLbl, a64dec_tb_pkg::SlotImm,
                            a64dec_tb_pkg::SlotReg};
            d.reg_first = rcode(rd, sf, 1'b0);
            d.immediate = {58'd0, sf, w[23:19]};
            d.target = pc + (sx({50'd0, w[18:5]}, 14) << 2);
        end
        else if ((op0 & 7'h7E) == 7'h6A)
        begin
            opc4 = w[24:21];
            if (opc4 == 4'd0)
            begin
                d.mnemonic_id = 7'd33;
                d.category = a64dec_tb_pkg::CatBranch;
                d.flags = a64dec_tb_pkg::FlBranch;
            end
            else if (opc4 == 4'd1)
            begin
                d.mnemonic_id = 7'd34;
                d.category = a64dec_tb_pkg::CatCall;
                d.flags = a64dec_tb_pkg::FlBranch | a64dec_tb_pkg::FlCall;
            end
            else if (opc4 == 4'd2)
            begin
                d.mnemonic_id = 7'd35;
                d.category = a64dec_tb_pkg::CatReturn;
                d.flags = a64dec_tb_pkg::FlBranch | a64dec_tb_pkg::FlRet;
            end
            else
            begin
                d.mnemonic_id = 7'd36;
                d.category = a64dec_tb_pkg::CatBranch;
            end
            if (!(opc4 == 4'd2 && rn == 5'd30))
            begin
                d.operand_count = 2'd1;
                d.slot_kinds = {6'd0, a64dec_tb_pkg::SlotReg};
                d.reg_first = rcode(rn, 1'b1, 1'b0);
            end
        end
        else if ((op0 & 7'h0A) == 7'h08)
        begin
            size = w[31:30];
            ld = w[22];
            if (w[29:28] == 2'd3 && w[25:24] == 2'd1)
            begin
                d.mnemonic_id = ld ? 7'd37 : 7'd38;
                d.category = a64dec_tb_pkg::CatTransfer;
                d.operand_count = 2'd2;
                d.flags = ld ? a64dec_tb_pkg::FlLoad : a64dec_tb_pkg::FlStore;
                d.slot_kinds = {3'd0, a64dec_tb_pkg::SlotMem, a64dec_tb_pkg::SlotReg};
                d.reg_first = rcode(rd, size == 2'd3, 1'b0);
                d.reg_second = rcode(rn, 1'b1, 1'b1);
                d.immediate = {52'd0, w[21:10]} << size;
            end
            else if (w[29:27] == 3'd5)
            begin
                d.mnemonic_id = ld ? 7'd39 : 7'd40;
                d.category = ld ? a64dec_tb_pkg::CatTransfer : a64dec_tb_pkg::CatStack;
                d.operand_count = 2'd3;
                d.flags = ld ? a64dec_tb_pkg::FlLoad : a64dec_tb_pkg::FlStore;
                d.slot_kinds = {a64dec_tb_pkg::SlotMem, a64dec_tb_pkg::SlotReg,
                                a64dec_tb_pkg::SlotReg};
                d.reg_first = rcode(rd, sf, 1'b0);
                d.reg_second = rcode(w[14:10], sf, 1'b0);
                d.reg_third = rcode(rn, 1'b1, 1'b1);
                d.immediate = sx({57'd0, w[21:15]}, 7) << (sf ? 3 : 2);
            end
            else
            begin
                d.mnemonic_id = 7'd41;
                d.category = a64dec_tb_pkg::CatTransfer;
            end
        end
        else if ((op0 & 7'h0E) == 7'h0A)
        begin
            opc = w[30:29];
            setf = w[29];
            neg = w[21];
            cls = w[28:24];
            if ((cls & 5'h1E) == 5'h0A)
            begin
                if (opc == 2'd1 && !neg && rn == 5'd31 && w[15:10] == 0 && w[23:22] == 0)
                begin
                    d.mnemonic_id = 7'd50;
                    d.category = a64dec_tb_pkg::CatTransfer;
                    d.operand_count = 2'd2;
                    d.slot_kinds = {3'd0, a64dec_tb_pkg::SlotReg, a64dec_tb_pkg::SlotReg};
                    d.reg_first = rcode(rd, sf, 1'b0);
                    d.reg_second = rcode(rm, sf, 1'b0);
                end
                else
                begin
                    d.mnemonic_id = 7'd42 + (neg ? 7'd4 : 7'd0) + {5'd0, opc};
                    d.category = a64dec_tb_pkg::CatLogical;
                    d.operand_count = 2'd3;
                    d.slot_kinds = {a64dec_tb_pkg::SlotReg, a64dec_tb_pkg::SlotReg,
                                    a64dec_tb_pkg::SlotReg};
                    d.reg_first = rcode(rd, sf, 1'b0);
                    d.reg_second = rcode(rn, sf, 1'b0);
                    d.reg_third = rcode(rm, sf, 1'b0);
                end
            end
            else if (cls == 5'h0B)
            begin
                sub = w[30];
                if (sub && rd == 5'd31 && setf)
                begin
                    d.mnemonic_id = 7'd2;
                    d.category = a64dec_tb_pkg::CatCompare;
                    d.operand_count = 2'd2;
                    d.slot_kinds = {3'd0, a64dec_tb_pkg::SlotReg, a64dec_tb_pkg::SlotReg};
                    d.reg_first = rcode(rn, sf, 1'b1);
                    d.reg_second = rcode(rm, sf, 1'b0);
                end
                else
                begin
                    d.mnemonic_id = 7'd3 + (sub ? 7'd2 : 7'd0) + (setf ? 7'd1 : 7'd0);
                    d.category = a64dec_tb_pkg::CatArith;
                    d.operand_count = 2'd3;
                    d.slot_kinds = {a64dec_tb_pkg::SlotReg, a64dec_tb_pkg::SlotReg,
                                    a64dec_tb_pkg::SlotReg};
                    d.reg_first = rcode(rd, sf, !setf);
                    d.reg_second = rcode(rn, sf, 1'b1);
                    d.reg_third = rcode(rm, sf, 1'b0);
                end
            end
            else
            begin
                d.mnemonic_id = 7'd51;
                d.category = a64dec_pkg::CatOther;
            end
        end
        else if ((w & 32'hFFC00000) == 32'hD5000000)
        begin
            o1 = w[18:16];
            crn = w[15:12];
            crm = w[11:8];
            o2 = w[7:5];
            d.category = a64dec_tb_pkg::CatSystem;
            if (w[20:19] == 2'd1 && !w[21] && rd == 5'd31)
            begin
                if (crn == 4'd2 && o1 == 3'd3)
                begin
                    h = {crm, o2} > 7'd5 ? 6'd63 : {crm[2:0], o2};
                    if ({crm, o2} <= 7'd5)
                        d.mnemonic_id = 7'd52 + {1'b0, h};
                    else
                        d.mnemonic_id = 7'd58;
                    if ({crm, o2} == 7'd0)
                        d.category = a64dec_tb_pkg::CatNop;
                end
                else if (crn == 4'd3)
                begin
                    case (o2)
                        3'd2: d.mnemonic_id = 7'd59;
                        3'd4: d.mnemonic_id = 7'd60;
                        3'd5: d.mnemonic_id = 7'd61;
                        3'd6: d.mnemonic_id = 7'd62;
                        default: d.mnemonic_id = 7'd63;
                    endcase
                end
                else
                    d.mnemonic_id = 7'd64;
            end
            else if (w[20:19] >= 2'd2)
            begin
                d.mnemonic_id = w[21] ? 7'd65 : 7'd66;
                d.operand_count = 2'd1;
                d.slot_kinds = {6'd0, a64dec_tb_pkg::SlotReg};
                d.reg_first = rcode(rd, 1'b1, 1'b0);
            end
            else
                d.mnemonic_id = 7'd64;
        end
        else if ((w & 32'hFF000000) == 32'hD4000000)
        begin
            k = {w[23:21], w[1:0]};
            if (k >= 5'd1 && k <= 5'd4)
                d.mnemonic_id = 7'd66 + {2'd0, k};
            else if (k == 5'd8)
                d.mnemonic_id = 7'd71;
            else
                d.mnemonic_id = 7'd72;
            d.category = a64dec_tb_pkg::CatSystem;
            d.operand_count = 2'd1;
            d.slot_kinds = {6'd0, a64dec_tb_pkg::SlotImm};
            d.immediate = {48'd0, w[20:5]};
        end
        if ((w & 32'hFFC07FFF) == 32'hA9007BFD || (w & 32'hFF0003FF) == 32'hD10003FF ||
            w == 32'hD503233F || w == 32'hD503237F)
            d.flags |= a64dec_tb_pkg::FlPro;
        if ((w & 32'hFFFFFC1F) == 32'hD65F0000 || w == 32'hD65F0BFF || w == 32'hD65F0FFF)
            d.flags |= a64dec_tb_pkg::FlEpi;
        return d;
    endfunction

    // Words from a random class template with random payload bits, or a fully random word.
    function automatic logic [31:0] shaped_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 17))
            0: return (r & 32'h9FFFFFFF) | 32'h10000000;
            1: return (r & 32'hFF3FFFFF) | 32'h11000000;
            2: return (r & 32'hFF9FFFFF) | 32'h12800000;
            3: return (r & 32'h83FFFFFF) | 32'h14000000;
            4: return (r & 32'hFEFFFFFF) | 32'h34000000;
            5: return (r & 32'h00FFFFEF) | 32'h54000000;
            6: return (r & 32'h81FFFFFF) | 32'h36000000;
            7: return (r & 32'h01FFFC1F) | 32'hD6000000 | ($urandom_range(0, 3) << 21);
            8: return (r & 32'hC07FFFFF) | 32'h39000000 | ($urandom_range(0, 1) << 22);
            9: return (r & 32'h807FFFFF) | 32'h29000000 | ($urandom_range(0, 1) << 22);
            10: return (r & 32'hE0FFFFFF) | 32'h0A000000;
            11: return (r & 32'hE0FFFFFF) | 32'h0B000000;
            12: return (r & 32'h801F0000) | 32'h2A0003E0;
            13: return (r & 32'h003FFFFF) | 32'hD5000000;
            14: return 32'hD503201F | (($urandom_range(0, 7) << 5) | ($urandom_range(0, 1) << 8));
            15: return 32'hD503301F | ($urandom_range(0, 7) << 5) | (r & 32'h00000F00);
            16: return (r & 32'h00FFFFFF) | 32'hD4000000;
            default: return r;
        endcase
    endfunction

    task automatic add_vec(input logic [31:0] w, input logic whole, input logic [63:0] pc);
        vector_t v;
        v.word = w;
        v.whole = whole;
        v.pc = pc;
        v.known = 1'b0;
        v.res = '0;
        vectors.push_back(v);
    endtask

    task automatic add_known(input logic [31:0] w, input logic whole, input logic [63:0] pc,
                             input a64dec_pkg::result_t r);
        vector_t v;
        v.word = w;
        v.whole = whole;
        v.pc = pc;
        v.known = 1'b1;
        v.res = r;
        vectors.push_back(v);
    endtask

    function automatic a64dec_pkg::result_t mk(input logic dec, input logic [6:0] mn,
                                               input logic [3:0] cat,
                                               input logic [1:0] cnt, input logic [8:0] kinds,
                                               input logic [6:0] r0, input logic [6:0] r1,
                                               input logic [63:0] imm, input logic [63:0] tgt,
                                               input logic [7:0] fl);
        a64dec_pkg::result_t r;
        r = '0;
        r.decoded = dec;
        r.mnemonic_id = mn;
        r.category = cat;
        r.operand_count = cnt;
        r.slot_kinds = kinds;
        r.reg_first = r0;
        r.reg_second = r1;
        r.immediate = imm;
        r.target = tgt;
        r.flags = fl;
        return r;
    endfunction

    task automatic build_table();
        // short word, fields zero but for the unknown mnemonic and the other category
        add_known(32'hFFFFFFFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                  mk(1'b0, a64dec_pkg::MnUnknown, a64dec_pkg::CatOther, 2'd0, 9'd0,
                     7'd0, 7'd0, 64'd0, 64'd0, 8'd0));
        // hint word, lands in the branch-register class
        add_vec(32'hD503201F, 1'b1, 64'h0);
        // ret x30, epilogue
        add_known(32'hD65F03C0, 1'b1, 64'h1000,
                  mk(1'b1, 7'd35, a64dec_tb_pkg::CatReturn, 2'd0, 9'd0, 7'd0, 7'd0,
                     64'd0, 64'd0,
                     a64dec_tb_pkg::FlBranch | a64dec_tb_pkg::FlRet | a64dec_tb_pkg::FlEpi));
        // cbz w0, -4 wraps below zero
        add_known(32'h68FFFFE0, 1'b1, 64'h0,
                  mk(1'b1, 7'd13, a64dec_tb_pkg::CatBranch, 2'd2,
                     {3'd0, a64dec_tb_pkg::SlotLbl, a64dec_tb_pkg::SlotReg}, 7'd33, 7'd0,
                     64'd0, 64'hFFFF_FFFF_FFFF_FFFC,
                     a64dec_tb_pkg::FlBranch | a64dec_tb_pkg::FlCond));
        add_vec(32'h17FFFFFF, 1'b1, 64'h0);
        add_vec(32'h00000000, 1'b1, 64'h0);
        add_vec(32'hA9BF7BFD, 1'b1, 64'h4000);
        add_vec(32'hD10043FF, 1'b1, 64'h4004);
        add_vec(32'hD503233F, 1'b1, 64'h4008);
        add_vec(32'hD503237F, 1'b1, 64'h400C);
        add_vec(32'hD65F0BFF, 1'b1, 64'h0);
        add_vec(32'hD65F0FFF, 1'b1, 64'h0);
        add_vec(32'h94000001, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0);
        add_vec(32'hF0FFFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        add_vec(32'h72800000, 1'b1, 64'h0);
        add_vec(32'hF100043F, 1'b1, 64'h0);
        add_vec(32'hEB01001F, 1'b1, 64'h0);
        add_vec(32'hAA0103E0, 1'b1, 64'h0);
        add_vec(32'hD4000001, 1'b1, 64'h0);
        add_vec(32'hD4200000, 1'b1, 64'h0);
        add_vec(32'hD4400000, 1'b1, 64'h0);
        add_vec(32'hD53BD040, 1'b1, 64'h0);
        add_vec(32'hD503309F, 1'b1, 64'h0);
        add_vec(32'hD63F0000, 1'b1, 64'h0);
        add_vec(32'hF9400000, 1'b1, 64'h0);
        add_vec(32'h547FFFEF, 1'b1, 64'h8000_0000_0000_0000);
    endtask

    task automatic check_result(input a64dec_pkg::result_t got, input a64dec_pkg::result_t exp);
        if (got !== exp)
        begin
            fail_count++;
            $display("%0t: mismatch dec %b/%b mn %0d/%0d cat %0d/%0d cnt %0d/%0d kinds %h/%h",
                     $time, exp.decoded, got.decoded, exp.mnemonic_id, got.mnemonic_id,
                     exp.category, got.category, exp.operand_count, got.operand_count,
                     exp.slot_kinds, got.slot_kinds);
            $display("%0t:   regs %0d %0d %0d / %0d %0d %0d imm %h/%h tgt %h/%h flags %h/%h",
                     $time, exp.reg_first, exp.reg_second, exp.reg_third, got.reg_first,
                     got.reg_second, got.reg_third, exp.immediate, got.immediate,
                     exp.target, got.target, exp.flags, got.flags);
        end
    endtask

    task automatic send_item(input vector_t v);
        a64dec_pkg::result_t p;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.instruction_word <= v.word;
        in_ch.whole_word <= v.whole;
        in_ch.pc_address <= v.pc;
        p = predict_decode(v.word, v.whole, v.pc);
        if (v.known && p !== v.res)
        begin
            fail_count++;
            $display("%0t: table row %h disagrees with prediction", $time, v.word);
        end
        expected_decodes.push_back(v.known ? v.res : p);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            a64dec_pkg::result_t got;
            got.decoded = out_ch.decoded;
            got.mnemonic_id = out_ch.mnemonic_id;
            got.category = out_ch.category;
            got.operand_count = out_ch.operand_count;
            got.slot_kinds = out_ch.slot_kinds;
            got.reg_first = out_ch.reg_first;
            got.reg_second = out_ch.reg_second;
            got.reg_third = out_ch.reg_third;
            got.immediate = out_ch.immediate;
            got.target = out_ch.target;
            got.flags = out_ch.flags;
            if (expected_decodes.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result, mnemonic %0d", $time, got.mnemonic_id);
            end
            else
                check_result(got, expected_decodes.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if ($urandom_range(0, 19) == 0)
            out_ch.ready <= 1'b0;
        else if ($urandom_range(0, 2) == 0)
            out_ch.ready <= ($urandom_range(0, 6) != 0);
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("** aarch64_instruction_decoder_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        fail_count = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.instruction_word = '0;
        in_ch.whole_word = 1'b0;
        in_ch.pc_address = '0;
        out_ch.ready = 1'b0;
        build_table();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (vectors[i])
            send_item(vectors[i]);
        for (int n = 0; n < NumRandom; n++)
        begin
            vector_t v;
            logic [31:0] w;
            w = ($urandom_range(0, 4) == 0) ? $urandom : shaped_word();
            v.word = w;
            v.whole = ($urandom_range(0, 15) != 0);
            v.pc = {$urandom, $urandom};
            v.known = 1'b0;
            v.res = '0;
            if (n == NumRandom / 2)
            begin
                in_ch.valid <= 1'b0;
                while (expected_decodes.size() != 0)
                    @(negedge clk);
            end
            send_item(v);
            if (n % 64 == 63)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
        end
        in_ch.valid <= 1'b0;
        while (expected_decodes.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && expected_decodes.size() == 0)
            $display("** aarch64_instruction_decoder_unit: PASSED **");
        else
            $display("** aarch64_instruction_decoder_unit: FAILED **");
        $finish;
    end
endmodule
